// File: hdl/dstp_pkg.sv
// shared types, constants and helper functions of the draw string parser
package dstp_pkg;

  localparam int TEXT_W   = 8;
  localparam int COORD_W  = 16;
  localparam int MAG_W    = COORD_W - 1;
  localparam int ACC_W    = MAG_W + 4;
  localparam int SUM_W    = COORD_W + 2;
  localparam int SCREEN_W = 11;
  localparam int CMP_W    = (COORD_W > SCREEN_W) ? COORD_W : SCREEN_W;
  localparam int KIND_W   = 3;
  localparam int DIR_W    = 4;
  localparam int COLOR_W  = 4;
  localparam int ROP_W    = 3;
  localparam int NUM_REGS = 4;
  localparam int IDX_W    = $clog2(NUM_REGS);
  localparam int ADDR_W   = IDX_W + 2;
  localparam int DATA_W   = 32;

  localparam logic [MAG_W-1:0]   MAG_MAX   = {MAG_W{1'b1}};
  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [ACC_W-1:0]   RADIX     = ACC_W'(10);
  localparam logic [TEXT_W-1:0]  CASE_OFFSET = 8'h20;
  localparam logic [TEXT_W-1:0]  CHAR_TAB  = 8'h09;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_MOVE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LINE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DONE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SYNTAX = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RANGE  = 3'd4;

  // register indexes
  localparam logic [IDX_W-1:0] REG_DRAW_COLOR    = 2'd0;
  localparam logic [IDX_W-1:0] REG_RASTER_OP     = 2'd1;
  localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd2;
  localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd3;

  localparam logic [COLOR_W-1:0]  RESET_COLOR  = 4'd15;
  localparam logic [ROP_W-1:0]    RESET_ROP    = 3'd0;
  localparam logic [SCREEN_W-1:0] RESET_WIDTH  = 11'd256;
  localparam logic [SCREEN_W-1:0] RESET_HEIGHT = 11'd192;

  // direction codes
  localparam logic [DIR_W-1:0] DIR_NONE = 4'd0;
  localparam logic [DIR_W-1:0] DIR_U    = 4'd1;
  localparam logic [DIR_W-1:0] DIR_D    = 4'd2;
  localparam logic [DIR_W-1:0] DIR_L    = 4'd3;
  localparam logic [DIR_W-1:0] DIR_R    = 4'd4;
  localparam logic [DIR_W-1:0] DIR_E    = 4'd5;
  localparam logic [DIR_W-1:0] DIR_F    = 4'd6;
  localparam logic [DIR_W-1:0] DIR_G    = 4'd7;
  localparam logic [DIR_W-1:0] DIR_H    = 4'd8;

  // unit step along one axis
  localparam logic [1:0] STEP_ZERO = 2'b00;
  localparam logic [1:0] STEP_POS  = 2'b01;
  localparam logic [1:0] STEP_NEG  = 2'b10;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LETTER,
    PH_DIST,
    PH_BWAIT,
    PH_MX_PRE,
    PH_MX_NUM,
    PH_MY_PRE,
    PH_MY_NUM
  } phase_t;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [COORD_W-1:0] from_x;
    logic signed [COORD_W-1:0] from_y;
    logic signed [COORD_W-1:0] to_x;
    logic signed [COORD_W-1:0] to_y;
    logic                      string_end;
  } seg_t;

  function automatic logic [DIR_W-1:0] dir_code(input logic [TEXT_W-1:0] c);
    logic [DIR_W-1:0] code;
    case (c)
      "U":     code = DIR_U;
      "D":     code = DIR_D;
      "L":     code = DIR_L;
      "R":     code = DIR_R;
      "E":     code = DIR_E;
      "F":     code = DIR_F;
      "G":     code = DIR_G;
      "H":     code = DIR_H;
      default: code = DIR_NONE;
    endcase
    return code;
  endfunction

  function automatic logic [1:0] step_x(input logic [DIR_W-1:0] code);
    logic [1:0] s;
    case (code)
      DIR_L, DIR_G, DIR_H: s = STEP_NEG;
      DIR_R, DIR_E, DIR_F: s = STEP_POS;
      default:             s = STEP_ZERO;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] step_y(input logic [DIR_W-1:0] code);
    logic [1:0] s;
    case (code)
      DIR_U, DIR_E, DIR_H: s = STEP_NEG;
      DIR_D, DIR_F, DIR_G: s = STEP_POS;
      default:             s = STEP_ZERO;
    endcase
    return s;
  endfunction

  // pen plus or minus a distance, saturated to the coordinate range
  function automatic logic signed [COORD_W-1:0] step_clamp(
    input logic signed [COORD_W-1:0] pen,
    input logic signed [COORD_W-1:0] delta,
    input logic [1:0]                step
  );
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-COORD_W:0]  top;
    logic [COORD_W-1:0]      res;
    case (step)
      STEP_POS: sum = SUM_W'(pen) + SUM_W'(delta);
      STEP_NEG: sum = SUM_W'(pen) - SUM_W'(delta);
      default:  sum = SUM_W'(pen);
    endcase
    top = sum[SUM_W-1:COORD_W-1];
    if ((&top) || !(|top)) begin
      res = sum[COORD_W-1:0];
    end else if (sum[SUM_W-1]) begin
      res = COORD_MIN;
    end else begin
      res = COORD_MAX;
    end
    return res;
  endfunction

endpackage

// File: hdl/dstp_if.sv
// handshake channels for command text bytes and segment results

interface dstp_text_if;
  logic                          valid;
  logic                          ready;
  logic [dstp_pkg::TEXT_W-1:0]   text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface dstp_seg_if;
  logic                                 valid;
  logic                                 ready;
  logic [dstp_pkg::KIND_W-1:0]          kind;
  logic signed [dstp_pkg::COORD_W-1:0]  from_x;
  logic signed [dstp_pkg::COORD_W-1:0]  from_y;
  logic signed [dstp_pkg::COORD_W-1:0]  to_x;
  logic signed [dstp_pkg::COORD_W-1:0]  to_y;
  logic                                 string_end;

  modport source (output valid, output kind, output from_x, output from_y, output to_x,
                  output to_y, output string_end, input ready);
  modport sink (input valid, input kind, input from_x, input from_y, input to_x,
                input to_y, input string_end, output ready);
endinterface

// File: hdl/draw_string_turtle_parser.sv
// draw string parser: turns DRAW command bytes into pen move and line segment items
//
// The block reads one byte of a DRAW string per item on cmd and ends a string at a
// zero byte. Commands U D L R E F G H take an optional signed distance (default 1),
// a B prefix turns the next direction command into a move without drawing, and
// M x,y moves the pen to an absolute position; case is ignored and space, tab and
// comma separate tokens. A command is finished by the first byte that cannot extend
// it, so its segment item leaves on that byte; each byte yields at most one item on
// seg. Off-screen absolute or B moves give a range error item, malformed text gives
// a syntax error item, and after an error bytes are dropped up to the zero byte.
// Each byte is parsed in one pass of logic: the parse state and the pen update in
// that pass behind the state registers, and the result is written to a two-entry
// output buffer, so cmd takes one byte per cycle and only stalls once both buffer
// entries are held by a stalled seg. A result is registered in the buffer before
// seg shows it. Registers sit on the APB port at byte addresses 0 (colour),
// 4 (raster op), 8 (screen width) and 12 (screen height); write them only while idle.
module draw_string_turtle_parser (
  input  logic                           clk,
  input  logic                           rst,
  dstp_text_if.sink                      cmd,
  dstp_seg_if.source                     seg,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dstp_pkg::ADDR_W-1:0]    paddr,
  input  logic [dstp_pkg::DATA_W-1:0]    pwdata,
  output logic [dstp_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  // configuration registers
  logic [dstp_pkg::COLOR_W-1:0]  draw_color;
  logic [dstp_pkg::ROP_W-1:0]    raster_op;
  logic [dstp_pkg::SCREEN_W-1:0] screen_width;
  logic [dstp_pkg::SCREEN_W-1:0] screen_height;
  logic [dstp_pkg::IDX_W-1:0]    reg_idx;
  logic                          reg_write;

  // parse state
  dstp_pkg::phase_t                    phase, phase_next;
  logic signed [dstp_pkg::COORD_W-1:0] pen_x, pen_x_next;
  logic signed [dstp_pkg::COORD_W-1:0] pen_y, pen_y_next;
  logic [dstp_pkg::MAG_W-1:0]          number_value, number_value_next;
  logic                                number_negative, number_negative_next;
  logic                                digit_seen, digit_seen_next;
  logic [dstp_pkg::DIR_W-1:0]          direction_code, direction_code_next;
  logic                                move_only_flag, move_only_flag_next;
  logic signed [dstp_pkg::COORD_W-1:0] first_coordinate, first_coordinate_next;
  logic                                error_hold, error_hold_next;

  // byte classes
  logic [dstp_pkg::TEXT_W-1:0] tb;
  logic [dstp_pkg::TEXT_W-1:0] upper_b;
  logic [dstp_pkg::DIR_W-1:0]  code_in;
  logic is_end, is_dig, is_sign, is_minus, is_blank, is_sep, is_letter_m, is_letter_b;

  // number and target datapath
  logic [dstp_pkg::ACC_W-1:0]          acc;
  logic [dstp_pkg::MAG_W-1:0]          acc_sat;
  logic [dstp_pkg::MAG_W-1:0]          first_digit;
  logic signed [dstp_pkg::COORD_W-1:0] mag_ext;
  logic signed [dstp_pkg::COORD_W-1:0] num_signed;
  logic signed [dstp_pkg::COORD_W-1:0] step_len;
  logic signed [dstp_pkg::COORD_W-1:0] dir_x, dir_y;
  logic signed [dstp_pkg::COORD_W-1:0] tgt_x, tgt_y;
  logic                                tgt_move, on_screen, dir_bad;

  // per byte events
  logic fin_dir, fin_abs, fin_any, syn_fail, range_fail, do_fail, place_ok, res_valid;
  dstp_pkg::seg_t res;

  // output buffer
  logic           head_valid, skid_valid;
  dstp_pkg::seg_t head, skid;
  logic           cmd_fire, push, pop;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = paddr[dstp_pkg::ADDR_W-1:2];
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_color    <= dstp_pkg::RESET_COLOR;
      raster_op     <= dstp_pkg::RESET_ROP;
      screen_width  <= dstp_pkg::RESET_WIDTH;
      screen_height <= dstp_pkg::RESET_HEIGHT;
    end else if (reg_write) begin
      case (reg_idx)
        dstp_pkg::REG_DRAW_COLOR:    draw_color    <= pwdata[dstp_pkg::COLOR_W-1:0];
        dstp_pkg::REG_RASTER_OP:     raster_op     <= pwdata[dstp_pkg::ROP_W-1:0];
        dstp_pkg::REG_SCREEN_WIDTH:  screen_width  <= pwdata[dstp_pkg::SCREEN_W-1:0];
        dstp_pkg::REG_SCREEN_HEIGHT: screen_height <= pwdata[dstp_pkg::SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dstp_pkg::REG_DRAW_COLOR:    prdata = dstp_pkg::DATA_W'(draw_color);
      dstp_pkg::REG_RASTER_OP:     prdata = dstp_pkg::DATA_W'(raster_op);
      dstp_pkg::REG_SCREEN_WIDTH:  prdata = dstp_pkg::DATA_W'(screen_width);
      dstp_pkg::REG_SCREEN_HEIGHT: prdata = dstp_pkg::DATA_W'(screen_height);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // byte decode
  // ---------------------------------------------------------------------------
  assign tb          = cmd.text_byte;
  assign is_end      = (tb == '0);
  assign is_dig      = tb inside {["0":"9"]};
  assign is_sign     = (tb == "+") || (tb == "-");
  assign is_minus    = (tb == "-");
  assign is_blank    = (tb == " ") || (tb == dstp_pkg::CHAR_TAB);
  assign is_sep      = is_blank || (tb == ",");
  assign upper_b     = (tb inside {["a":"z"]}) ? tb - dstp_pkg::CASE_OFFSET : tb;
  assign is_letter_m = (upper_b == "M");
  assign is_letter_b = (upper_b == "B");
  assign code_in     = dstp_pkg::dir_code(upper_b);

  // decimal accumulation, saturating at the largest coordinate magnitude
  assign acc = dstp_pkg::ACC_W'(number_value) * dstp_pkg::RADIX +
               dstp_pkg::ACC_W'(tb[3:0]);
  assign acc_sat = (acc > dstp_pkg::ACC_W'(dstp_pkg::MAG_MAX)) ? dstp_pkg::MAG_MAX :
                   acc[dstp_pkg::MAG_W-1:0];
  assign first_digit = is_dig ? dstp_pkg::MAG_W'(tb[3:0]) : '0;

  assign mag_ext    = {1'b0, number_value};
  assign num_signed = number_negative ? -mag_ext : mag_ext;
  assign step_len   = digit_seen ? num_signed : dstp_pkg::COORD_W'(1);

  // relative target, one unit step per axis scaled by the distance
  assign dir_x   = dstp_pkg::step_clamp(pen_x, step_len, dstp_pkg::step_x(direction_code));
  assign dir_y   = dstp_pkg::step_clamp(pen_y, step_len, dstp_pkg::step_y(direction_code));
  assign dir_bad = (direction_code == dstp_pkg::DIR_NONE) ||
                   (direction_code > dstp_pkg::DIR_H);

  // a command is finished by a byte that cannot extend it
  assign fin_dir = !error_hold &&
                   (((phase == dstp_pkg::PH_LETTER) && !is_sign && !is_dig) ||
                    ((phase == dstp_pkg::PH_DIST) && !is_dig && digit_seen));
  assign fin_abs = !error_hold && (phase == dstp_pkg::PH_MY_NUM) && !is_dig && digit_seen;
  assign fin_any = (fin_dir && !dir_bad) || fin_abs;

  assign tgt_x    = fin_abs ? first_coordinate : dir_x;
  assign tgt_y    = fin_abs ? num_signed : dir_y;
  assign tgt_move = fin_abs || move_only_flag;

  // lines are left to the drawer to clip; moves must land on screen
  assign on_screen = !tgt_x[dstp_pkg::COORD_W-1] && !tgt_y[dstp_pkg::COORD_W-1] &&
                     (dstp_pkg::CMP_W'($unsigned(tgt_x)) <
                      dstp_pkg::CMP_W'(screen_width)) &&
                     (dstp_pkg::CMP_W'($unsigned(tgt_y)) <
                      dstp_pkg::CMP_W'(screen_height));

  always_comb begin
    syn_fail = 1'b0;
    if (!error_hold) begin
      case (phase)
        dstp_pkg::PH_DIST, dstp_pkg::PH_MY_NUM: syn_fail = !is_dig && !digit_seen;
        dstp_pkg::PH_MX_NUM:                    syn_fail = !is_dig &&
                                                           (!digit_seen ||
                                                            (!is_sep && !is_sign));
        dstp_pkg::PH_BWAIT:                     syn_fail = is_end;
        dstp_pkg::PH_MX_PRE, dstp_pkg::PH_MY_PRE:
                                                syn_fail = !is_sep && !is_sign && !is_dig;
        dstp_pkg::PH_LETTER:                    syn_fail = fin_dir && dir_bad;
        default:                                syn_fail = 1'b0;
      endcase
      if ((phase == dstp_pkg::PH_DIST) && fin_dir && dir_bad) begin
        syn_fail = 1'b1;
      end
    end
  end

  assign range_fail = fin_any && tgt_move && !on_screen;
  assign place_ok   = fin_any && !range_fail;
  assign do_fail    = syn_fail || range_fail;
  assign res_valid  = do_fail || place_ok ||
                      (!error_hold && (phase == dstp_pkg::PH_IDLE) && is_end);

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_next            = phase;
    pen_x_next            = pen_x;
    pen_y_next            = pen_y;
    number_value_next     = number_value;
    number_negative_next  = number_negative;
    digit_seen_next       = digit_seen;
    direction_code_next   = direction_code;
    move_only_flag_next   = move_only_flag;
    first_coordinate_next = first_coordinate;
    error_hold_next       = error_hold;

    if (error_hold) begin
      // drop bytes until the string ends
      if (is_end) begin
        error_hold_next      = 1'b0;
        phase_next           = dstp_pkg::PH_IDLE;
        number_value_next    = '0;
        number_negative_next = 1'b0;
        digit_seen_next      = 1'b0;
      end
    end else if (do_fail) begin
      error_hold_next      = !is_end;
      phase_next           = dstp_pkg::PH_IDLE;
      number_value_next    = '0;
      number_negative_next = 1'b0;
      digit_seen_next      = 1'b0;
    end else if (place_ok || (phase == dstp_pkg::PH_IDLE)) begin
      if (place_ok) begin
        pen_x_next = tgt_x;
        pen_y_next = tgt_y;
      end
      // the finishing byte also starts the next token
      phase_next = dstp_pkg::PH_IDLE;
      if (is_end) begin
        number_value_next    = '0;
        number_negative_next = 1'b0;
        digit_seen_next      = 1'b0;
      end else if (!is_sep) begin
        number_value_next    = '0;
        number_negative_next = 1'b0;
        digit_seen_next      = 1'b0;
        if (is_letter_m) begin
          move_only_flag_next = 1'b0;
          phase_next          = dstp_pkg::PH_MX_PRE;
        end else if (is_letter_b) begin
          move_only_flag_next = 1'b1;
          phase_next          = dstp_pkg::PH_BWAIT;
        end else begin
          move_only_flag_next = 1'b0;
          direction_code_next = code_in;
          phase_next          = dstp_pkg::PH_LETTER;
        end
      end else if (place_ok) begin
        number_value_next    = '0;
        number_negative_next = 1'b0;
        digit_seen_next      = 1'b0;
      end
    end else begin
      case (phase)
        dstp_pkg::PH_LETTER, dstp_pkg::PH_MX_PRE, dstp_pkg::PH_MY_PRE: begin
          // sign or digit opens a number; separators before a coordinate are skipped
          if (is_sign || is_dig) begin
            number_value_next    = first_digit;
            number_negative_next = is_minus;
            digit_seen_next      = is_dig;
            case (phase)
              dstp_pkg::PH_LETTER: phase_next = dstp_pkg::PH_DIST;
              dstp_pkg::PH_MX_PRE: phase_next = dstp_pkg::PH_MX_NUM;
              default:             phase_next = dstp_pkg::PH_MY_NUM;
            endcase
          end
        end
        dstp_pkg::PH_DIST, dstp_pkg::PH_MY_NUM: begin
          if (is_dig) begin
            number_value_next = acc_sat;
            digit_seen_next   = 1'b1;
          end
        end
        dstp_pkg::PH_MX_NUM: begin
          if (is_dig) begin
            number_value_next = acc_sat;
            digit_seen_next   = 1'b1;
          end else begin
            // x is done; this byte is seen again as the start of y
            first_coordinate_next = num_signed;
            number_value_next     = '0;
            number_negative_next  = is_minus;
            digit_seen_next       = 1'b0;
            phase_next            = is_sep ? dstp_pkg::PH_MY_PRE : dstp_pkg::PH_MY_NUM;
          end
        end
        dstp_pkg::PH_BWAIT: begin
          if (!is_blank) begin
            direction_code_next = code_in;
            phase_next          = dstp_pkg::PH_LETTER;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result item
  // ---------------------------------------------------------------------------
  always_comb begin
    res.from_x     = pen_x;
    res.from_y     = pen_y;
    res.to_x       = pen_x;
    res.to_y       = pen_y;
    res.string_end = 1'b1;
    if (do_fail) begin
      res.kind = range_fail ? dstp_pkg::KIND_RANGE : dstp_pkg::KIND_SYNTAX;
    end else if (place_ok) begin
      res.kind       = tgt_move ? dstp_pkg::KIND_MOVE : dstp_pkg::KIND_LINE;
      res.to_x       = tgt_x;
      res.to_y       = tgt_y;
      res.string_end = is_end;
    end else begin
      res.kind = dstp_pkg::KIND_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= dstp_pkg::PH_IDLE;
      pen_x            <= '0;
      pen_y            <= '0;
      number_value     <= '0;
      number_negative  <= 1'b0;
      digit_seen       <= 1'b0;
      direction_code   <= dstp_pkg::DIR_NONE;
      move_only_flag   <= 1'b0;
      first_coordinate <= '0;
      error_hold       <= 1'b0;
    end else if (cmd_fire) begin
      phase            <= phase_next;
      pen_x            <= pen_x_next;
      pen_y            <= pen_y_next;
      number_value     <= number_value_next;
      number_negative  <= number_negative_next;
      digit_seen       <= digit_seen_next;
      direction_code   <= direction_code_next;
      move_only_flag   <= move_only_flag_next;
      first_coordinate <= first_coordinate_next;
      error_hold       <= error_hold_next;
    end
  end

  // ---------------------------------------------------------------------------
  // two-entry output buffer: head drives seg, skid catches an item while seg stalls
  // ---------------------------------------------------------------------------
  assign cmd.ready = !skid_valid;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign push      = cmd_fire && res_valid;
  assign pop       = head_valid && seg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push && head_valid && !pop) begin
      skid_valid <= 1'b1;
    end else if (push) begin
      head_valid <= 1'b1;
    end else if (pop) begin
      head_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        head <= skid;
      end
    end else if (push) begin
      if (head_valid && !pop) begin
        skid <= res;
      end else begin
        head <= res;
      end
    end
  end

  assign seg.valid      = head_valid;
  assign seg.kind       = head.kind;
  assign seg.from_x     = head.from_x;
  assign seg.from_y     = head.from_y;
  assign seg.to_x       = head.to_x;
  assign seg.to_y       = head.to_y;
  assign seg.string_end = head.string_end;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_hold_silent: assert property (@(posedge clk) disable iff (rst)
    error_hold |-> !res_valid)
    else $error("result produced while dropping bytes after an error");

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("skid entry held with empty head");

  a_pen_quiet: assert property (@(posedge clk) disable iff (rst)
    !(cmd_fire && place_ok) |=> $stable(pen_x) && $stable(pen_y))
    else $error("pen moved without a placed segment");

  a_error_ends: assert property (@(posedge clk) disable iff (rst)
    (push && do_fail) |=> error_hold == !$past(is_end))
    else $error("error hold does not follow the failing byte");

  a_err_item_end: assert property (@(posedge clk) disable iff (rst)
    (seg.valid && ((seg.kind == dstp_pkg::KIND_SYNTAX) ||
                   (seg.kind == dstp_pkg::KIND_RANGE))) |-> seg.string_end)
    else $error("error item without string end");

endmodule
